>>> hw/rtl/fbcd_pkg.sv
// Shared types and constants for the buffer cache directory.
// Used by every module of the block; depends on nothing.
package fbcd_pkg;

  // Directory geometry
  localparam int NumSlots  = 16;
  localparam int BlockBits = 16;
  localparam int SlotIdxW  = $clog2(NumSlots);
  localparam int CntW      = $clog2(NumSlots + 1);

  // Flush all stops after this many write-backs
  localparam int MaxRes  = 16;
  localparam int ResCntW = $clog2(MaxRes);

  // Command queue between front and back; depth is a power of two
  localparam int CmdQDepth = 4;
  localparam int CmdQPtrW  = $clog2(CmdQDepth);

  // Field widths of the stream payloads
  localparam int FuncW    = 2;
  localparam int BlkW     = 16;
  localparam int SlotFW   = 4;
  localparam int CfgW     = 17;
  localparam int InDataW  = 24;
  localparam int OutDataW = 24;

  localparam logic [CfgW-1:0] DiskBlockCountRst = CfgW'(65536);

  typedef enum logic [FuncW-1:0] {
    FuncGet       = 2'd0,
    FuncMarkDirty = 2'd1,
    FuncFlushSlot = 2'd2,
    FuncFlushAll  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    DiskNone  = 2'd0,
    DiskRead  = 2'd1,
    DiskWrite = 2'd2
  } disk_op_e;

  // Classified command as held in the queue
  typedef struct packed {
    func_e             func;
    logic [BlkW-1:0]   block_no;
    logic [SlotFW-1:0] slot;
    logic              out_of_range;
    logic              slot_ok;
  } cmd_t;

  // One result beat; packs to tdata with slot_out in the low bits
  typedef struct packed {
    logic [BlkW-1:0]   disk_block;
    disk_op_e          disk_op;
    logic              status;
    logic              hit;
    logic [SlotFW-1:0] slot_out;
  } res_t;

endpackage

>>> hw/rtl/fbcd_front.sv
// Front end: accepts input beats, decodes and range-checks them into commands.
// Depends on fbcd_pkg.
module fbcd_front import fbcd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // block_no, slot, zero pad
  input  logic [FuncW-1:0]    s_axis_tuser_i,   // func
  input  logic [CfgW-1:0]     cfg_count_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output cmd_t                cmd_o
);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic accept;
  logic [BlkW-1:0]   blk;
  logic [SlotFW-1:0] slot;

  assign s_axis_tready_o = !valid_q || cmd_ready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign blk             = s_axis_tdata_i[BlkW-1:0];
  assign slot            = s_axis_tdata_i[BlkW+SlotFW-1:BlkW];

  always_comb begin
    cmd_d   = cmd_q;
    valid_d = valid_q && !cmd_ready_i;
    if (accept) begin
      valid_d           = 1'b1;
      cmd_d.func         = func_e'(s_axis_tuser_i);
      cmd_d.block_no     = blk;
      cmd_d.slot         = slot;
      cmd_d.out_of_range = {1'b0, blk} >= cfg_count_i;
      cmd_d.slot_ok      = 32'(slot) < NumSlots;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

>>> hw/rtl/fbcd_cmd_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on fbcd_pkg.
module fbcd_cmd_queue import fbcd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  output logic   ready_o,
  input  cmd_t   cmd_i,
  input  logic   pop_i,     // pop from the consumer
  output logic   valid_o,   // valid toward the consumer
  output cmd_t   cmd_o
);

  cmd_t mem_q [CmdQDepth];
  logic [CmdQPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CmdQPtrW:0]   count_q;
  logic do_push, do_pop;

  assign ready_o = count_q != (CmdQPtrW+1)'(CmdQDepth);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= cmd_i;
  end

  assign valid_o = count_q != '0;
  assign cmd_o   = mem_q[rd_ptr_q];

endmodule

>>> hw/rtl/fbcd_back.sv
// Back end: tag store, load-order FIFO and the sequencer that emits results.
// Depends on fbcd_pkg.
module fbcd_back import fbcd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,  // valid from the command queue
  output logic                q_pop_o,    // pop toward the command queue
  input  cmd_t                cmd_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tlast_o
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StExec  = 4'b0010,
    StLoad  = 4'b0100,
    StFlush = 4'b1000
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd_q, cmd_d;

  logic [NumSlots-1:0]  valid_q, valid_d, dirty_q, dirty_d;
  logic [BlockBits-1:0] tag_q [NumSlots];
  logic [SlotIdxW-1:0]  fifo_mem_q [NumSlots];
  logic [SlotIdxW-1:0]  head_q, head_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [SlotIdxW-1:0]  victim_q, victim_d;
  logic [ResCntW-1:0]   res_cnt_q, res_cnt_d;

  res_t out_q, out_d;
  logic out_valid_q, out_valid_d, last_q, last_d;

  logic                 tag_we, fifo_we;
  logic [SlotIdxW-1:0]  tag_waddr, fifo_waddr;

  logic [BlockBits-1:0] blk_tag;
  logic [SlotIdxW-1:0]  slot_idx, hit_idx, free_idx, flush_idx, fifo_victim;
  logic [NumSlots-1:0]  hit_vec, vd_vec;
  logic                 can_emit, more_dirty;
  logic [CntW:0]        pos_sum;
  logic [SlotIdxW-1:0]  push_pos, head_next;

  function automatic logic [SlotIdxW-1:0] lowest_set(input logic [NumSlots-1:0] vec);
    logic [SlotIdxW-1:0] idx;
    idx = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (vec[i]) idx = SlotIdxW'(i);
    end
    return idx;
  endfunction

  assign blk_tag  = BlockBits'(cmd_q.block_no);
  assign slot_idx = SlotIdxW'(cmd_q.slot);

  always_comb begin
    for (int i = 0; i < NumSlots; i++) begin
      hit_vec[i] = valid_q[i] && (tag_q[i] == blk_tag);
    end
  end

  assign vd_vec     = valid_q & dirty_q;
  assign hit_idx    = lowest_set(hit_vec);
  assign free_idx   = lowest_set(~valid_q);
  assign flush_idx  = lowest_set(vd_vec);
  assign more_dirty = |(vd_vec & (vd_vec - 1'b1));

  // Slot at the FIFO head; slot 0 when the FIFO is empty
  assign fifo_victim = (count_q == '0) ? '0 : fifo_mem_q[head_q];
  assign head_next   = (head_q == SlotIdxW'(NumSlots - 1)) ? '0 : head_q + 1'b1;
  assign pos_sum     = (CntW+1)'(head_q) + (CntW+1)'(count_q);
  assign push_pos    = (pos_sum >= (CntW+1)'(NumSlots)) ?
                       SlotIdxW'(pos_sum - (CntW+1)'(NumSlots)) : SlotIdxW'(pos_sum);

  assign can_emit = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    valid_d     = valid_q;
    dirty_d     = dirty_q;
    head_d      = head_q;
    count_d     = count_q;
    victim_d    = victim_q;
    res_cnt_d   = res_cnt_q;
    out_d       = out_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    tag_we      = 1'b0;
    tag_waddr   = victim_q;
    fifo_we     = 1'b0;
    fifo_waddr  = push_pos;
    q_pop_o     = 1'b0;

    case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = cmd_i;
          state_d = StExec;
        end
      end

      StExec: begin
        if (can_emit) begin
          out_d       = '0;
          last_d      = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
          case (cmd_q.func)
            FuncGet: begin
              if (cmd_q.out_of_range) begin
                out_d.status = 1'b1;
              end else if (|hit_vec) begin
                out_d.hit      = 1'b1;
                out_d.slot_out = SlotFW'(hit_idx);
              end else begin
                state_d = StLoad;
                if (!(&valid_q)) begin
                  // Fill the lowest free slot
                  victim_d    = free_idx;
                  out_valid_d = out_valid_q && !m_axis_tready_i;
                end else begin
                  // Evict the oldest load, writing it back if dirty
                  victim_d = fifo_victim;
                  if (count_q != '0) begin
                    head_d  = head_next;
                    count_d = count_q - 1'b1;
                  end
                  if (dirty_q[fifo_victim]) begin
                    out_d.slot_out   = SlotFW'(fifo_victim);
                    out_d.disk_op    = DiskWrite;
                    out_d.disk_block = BlkW'(tag_q[fifo_victim]);
                    last_d           = 1'b0;
                  end else begin
                    out_valid_d = out_valid_q && !m_axis_tready_i;
                  end
                end
              end
            end
            FuncMarkDirty: begin
              if (cmd_q.slot_ok) dirty_d[slot_idx] = 1'b1;
              out_d.slot_out = cmd_q.slot;
            end
            FuncFlushSlot: begin
              out_d.slot_out = cmd_q.slot;
              if (cmd_q.slot_ok && valid_q[slot_idx] && dirty_q[slot_idx]) begin
                out_d.disk_op     = DiskWrite;
                out_d.disk_block  = BlkW'(tag_q[slot_idx]);
                dirty_d[slot_idx] = 1'b0;
              end
            end
            FuncFlushAll: begin
              if (vd_vec != '0) begin
                res_cnt_d   = '0;
                state_d     = StFlush;
                out_valid_d = out_valid_q && !m_axis_tready_i;
              end
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end

      StLoad: begin
        if (can_emit) begin
          tag_we            = 1'b1;
          valid_d[victim_q] = 1'b1;
          dirty_d[victim_q] = 1'b0;
          if (count_q < CntW'(NumSlots)) begin
            fifo_we = 1'b1;
            count_d = count_d + 1'b1;
          end
          out_d            = '0;
          out_d.slot_out   = SlotFW'(victim_q);
          out_d.disk_op    = DiskRead;
          out_d.disk_block = BlkW'(blk_tag);
          last_d           = 1'b1;
          out_valid_d      = 1'b1;
          state_d          = StIdle;
        end
      end

      StFlush: begin
        if (can_emit) begin
          dirty_d[flush_idx] = 1'b0;
          out_d              = '0;
          out_d.slot_out     = SlotFW'(flush_idx);
          out_d.disk_op      = DiskWrite;
          out_d.disk_block   = BlkW'(tag_q[flush_idx]);
          out_valid_d        = 1'b1;
          last_d             = !more_dirty || (res_cnt_q == ResCntW'(MaxRes - 1));
          res_cnt_d          = res_cnt_q + 1'b1;
          if (last_d) state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      dirty_q     <= '0;
      head_q      <= '0;
      count_q     <= '0;
      res_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      dirty_q     <= dirty_d;
      head_q      <= head_d;
      count_q     <= count_d;
      res_cnt_q   <= res_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    victim_q <= victim_d;
    out_q    <= out_d;
    last_q   <= last_d;
    if (tag_we)  tag_q[tag_waddr]       <= blk_tag;
    if (fifo_we) fifo_mem_q[fifo_waddr] <= victim_q;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tlast_o  = last_q;

endmodule

>>> hw/rtl/fifo_buffer_cache_directory.sv
// Top level of the buffer cache directory: front end, command queue, back end.
// Depends on fbcd_pkg, fbcd_front, fbcd_cmd_queue and fbcd_back.

// Directory for a fully associative 16-slot block buffer cache with FIFO
// replacement. Each input beat carries a command in tuser (get block, mark
// slot dirty, flush slot, flush all) and block_no/slot in tdata; each command
// answers with one or more result beats, the final one flagged by tlast.
// A get reports a hit, or picks the lowest free slot, or evicts the oldest
// loaded slot (a write-back beat first when it is dirty) and then issues a
// read beat; blocks at or above disk_block_count come back with status 1.
// Flush all emits one write-back per valid dirty slot, lowest slot first.
// The back-end sequencer handles one command at a time and sets the rate.
// The front register and the 4-deep command queue keep taking beats while
// the back end works or the output is stalled, until both are full.
// disk_block_count is written through cfg_we_i/cfg_wdata_i; the user must
// write it only while idle, which no logic in the block enforces.
module fifo_buffer_cache_directory import fbcd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,      // disk_block_count
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // [15:0] block_no, [19:16] slot, zero pad
  input  logic [FuncW-1:0]    s_axis_tuser_i,   // [1:0] func
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // [3:0] slot_out, [4] hit, [5] status,
                                                // [7:6] disk_op, [23:8] disk_block
  output logic                m_axis_tlast_o    // last
);

  logic [CfgW-1:0] cfg_count_q;

  logic   front_valid, queue_ready;
  cmd_t   front_cmd, queue_cmd;
  logic   queue_valid, back_pop;

  // Block count; the user must write it only while the pipeline is drained; unchecked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count_q <= DiskBlockCountRst;
    end else if (cfg_we_i) begin
      cfg_count_q <= cfg_wdata_i;
    end
  end

  // Decode and range-check incoming beats
  fbcd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cfg_count_i     (cfg_count_q),
    .cmd_valid_o     (front_valid),
    .cmd_ready_i     (queue_ready),
    .cmd_o           (front_cmd)
  );

  // Buffer commands so the front keeps accepting while the back is busy
  fbcd_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .ready_o (queue_ready),
    .cmd_i   (front_cmd),
    .pop_i   (back_pop),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  // Look up, replace and emit result beats
  fbcd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (queue_valid),
    .q_pop_o         (back_pop),
    .cmd_i           (queue_cmd),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

>>> hw/rtl/fbcd_checker.sv
// Port-level checks on the buffer cache directory result stream.
// Depends on fbcd_pkg; bound to fifo_buffer_cache_directory.
module fbcd_checker import fbcd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic                m_axis_tlast_o
);

  res_t res;
  assign res = m_axis_tdata_o;

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result beat changed while stalled");

  // An out-of-range get ends its command with no disk request
  a_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.status |->
      m_axis_tlast_o && !res.hit && (res.disk_op == DiskNone) && (res.slot_out == '0))
    else $error("bad out-of-range result");

  // A hit is a single beat with no disk request
  a_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.hit |-> m_axis_tlast_o && (res.disk_op == DiskNone))
    else $error("bad hit result");

  // A read request is always the final beat, and a beat with no request carries block 0
  a_read_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ((res.disk_op != DiskRead) || m_axis_tlast_o) &&
      ((res.disk_op != DiskNone) || (res.disk_block == '0)))
    else $error("bad disk request beat");

endmodule

bind fifo_buffer_cache_directory fbcd_checker u_fbcd_checker (.*);
